[design/fccm_pkg.sv]
// fccm_pkg: shared constants, payload structs and controller/datapath command types
// for the fat cluster chain manager. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fccm_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 4096;
   localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
   localparam int SECTOR_BYTES  = 512;
   localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);

   // field widths
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int CLUSTER_W = 16;
   localparam int LBA_W     = 32;
   localparam int SIZE_W    = 32;
   localparam int CC_W      = 12;
   localparam int SHIFT_W   = 3;
   localparam int LIMIT_W   = CLUSTER_W + 1;
   localparam int COUNT_W   = TABLE_AW + 1;
   localparam int NEED_W    = SIZE_W - SECTOR_SHIFT + 1;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START    = 2'd2;

   // entry codes
   localparam logic [CLUSTER_W-1:0] ENTRY_FREE    = 16'h0000;
   localparam logic [CLUSTER_W-1:0] ENTRY_END_MIN = 16'hFFF8;
   localparam logic [CLUSTER_W-1:0] ENTRY_END     = 16'hFFFF;
   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CL = 16'h0002;

   localparam logic [LIMIT_W-1:0] TABLE_LIMIT = LIMIT_W'(TABLE_ENTRIES);
   localparam logic [LIMIT_W-1:0] USABLE_MAX  = LIMIT_W'(TABLE_ENTRIES - 2);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [CLUSTER_W-1:0] cluster;
      logic [CLUSTER_W-1:0] entry_value;
      logic [SIZE_W-1:0]    byte_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [CLUSTER_W-1:0] value;
      logic [LBA_W-1:0]     sector_address;
   } rsp_type;

   // datapath micro-operations
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_READ_ENTRY,
      OP_WRITE_ENTRY,
      OP_PTR_READ,
      OP_FREE_CLEAR,
      OP_SCAN_START,
      OP_SCAN_NEXT,
      OP_LINK,
      OP_MARK,
      OP_UNWIND
   } dp_op_type;

   typedef enum logic [1:0] {
      VAL_ZERO,
      VAL_RDATA,
      VAL_FIRST
   } val_sel_type;

   typedef enum logic [1:0] {
      ADDR_ZERO,
      ADDR_REQ,
      ADDR_FIRST
   } addr_sel_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      val_sel_type         val_sel;
      addr_sel_type        addr_sel;
   } fin_type;

   typedef struct packed {
      dp_op_type op;
      logic      fin;
      fin_type   res;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              clr_last;
      logic              cl_in_table;
      logic              ptr_is_stop;
      logic              ptr_in_table;
      logic              scan_end;
      logic              entry_free;
      logic              first_zero;
      logic              need_zero;
      logic              alloc_last;
   } dp_sts_type;

endpackage

`default_nettype wire

[design/fccm_datapath.sv]
// fccm_datapath: allocation table memory, configuration registers, request and
// walk registers, result register. Depends on fccm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccm_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire  [fccm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [fccm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  fccm_pkg::req_type                   req_data,
   input  fccm_pkg::dp_cmd_type                cmd,
   output fccm_pkg::dp_sts_type                sts,
   output fccm_pkg::rsp_type                   rsp_data
);
   import fccm_pkg::*;

   localparam int DIV_SHIFT_W = 5;

   // configuration
   logic [CC_W-1:0]       cluster_count_ff;
   logic [SHIFT_W-1:0]    cluster_shift_ff;
   logic [LBA_W-1:0]      data_start_ff;

   // request and walk state
   logic [KIND_W-1:0]     kind_ff;
   logic [CLUSTER_W-1:0]  cl_ff;
   logic [CLUSTER_W-1:0]  ev_ff;
   logic [NEED_W-1:0]     need_ff;
   logic [NEED_W-1:0]     need_in;
   logic [CLUSTER_W-1:0]  ptr_ff;
   logic [TABLE_AW-1:0]   first_ff;
   logic [TABLE_AW-1:0]   tail_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [TABLE_AW-1:0]   clr_ff;

   // memory
   logic [CLUSTER_W-1:0]  fat_mem_ff [TABLE_ENTRIES];
   logic [CLUSTER_W-1:0]  rdata_ff;
   logic                  mem_we;
   logic [TABLE_AW-1:0]   mem_waddr;
   logic [CLUSTER_W-1:0]  mem_wdata;
   logic                  mem_re;
   logic [TABLE_AW-1:0]   mem_raddr;

   // result
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [CLUSTER_W-1:0]  res_val;
   logic [CLUSTER_W-1:0]  lba_cl;
   logic [LBA_W-1:0]      lba;

   // misc
   logic [DIV_SHIFT_W-1:0] div_shift;
   logic [SIZE_W-1:0]      quot;
   logic [SIZE_W-1:0]      rem_mask;
   logic                   rem_any;
   logic [LIMIT_W-1:0]     cc_ext;
   logic [LIMIT_W-1:0]     limit;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_count_ff <= '0;
         cluster_shift_ff <= '0;
         data_start_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLUSTER_COUNT: cluster_count_ff <= csr_wdata[CC_W-1:0];
            CSR_CLUSTER_SHIFT: cluster_shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_DATA_START:    data_start_ff    <= csr_wdata[LBA_W-1:0];
            default: ;
         endcase
      end
   end

   // cluster count: round size up to whole clusters
   always_comb begin
      div_shift = DIV_SHIFT_W'(SECTOR_SHIFT) + DIV_SHIFT_W'(cluster_shift_ff);
      quot      = req_data.byte_size >> div_shift;
      rem_mask  = (SIZE_W'(1) << div_shift) - SIZE_W'(1);
      rem_any   = |(req_data.byte_size & rem_mask);
      need_in   = NEED_W'(quot) + NEED_W'(rem_any);
   end

   // request latch and walk registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            kind_ff <= req_data.kind;
            cl_ff   <= req_data.cluster;
            ev_ff   <= req_data.entry_value;
            need_ff <= need_in;
            ptr_ff  <= req_data.cluster;
         end
         OP_SCAN_START: begin
            ptr_ff   <= FIRST_DATA_CL;
            first_ff <= '0;
            tail_ff  <= '0;
            count_ff <= '0;
         end
         OP_SCAN_NEXT: begin
            ptr_ff <= ptr_ff + CLUSTER_W'(1);
         end
         OP_MARK: begin
            if (tail_ff == '0) begin
               first_ff <= ptr_ff[TABLE_AW-1:0];
            end
            tail_ff  <= ptr_ff[TABLE_AW-1:0];
            count_ff <= count_ff + COUNT_W'(1);
            ptr_ff   <= ptr_ff + CLUSTER_W'(1);
         end
         OP_FREE_CLEAR: begin
            ptr_ff <= rdata_ff;
         end
         OP_UNWIND: begin
            ptr_ff <= CLUSTER_W'(first_ff);
         end
         default: ;
      endcase
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.op == OP_CLEAR) begin
         clr_ff <= clr_ff + TABLE_AW'(1);
      end
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_ff[TABLE_AW-1:0];
      mem_wdata = ENTRY_FREE;
      mem_re    = 1'b0;
      mem_raddr = ptr_ff[TABLE_AW-1:0];
      case (cmd.op)
         OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         OP_WRITE_ENTRY: begin
            mem_we    = 1'b1;
            mem_waddr = cl_ff[TABLE_AW-1:0];
            mem_wdata = ev_ff;
         end
         OP_FREE_CLEAR: begin
            mem_we = 1'b1;
         end
         OP_LINK: begin
            mem_we    = (tail_ff != '0);
            mem_waddr = tail_ff;
            mem_wdata = ptr_ff;
         end
         OP_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = ENTRY_END;
         end
         OP_READ_ENTRY: begin
            mem_re    = 1'b1;
            mem_raddr = cl_ff[TABLE_AW-1:0];
         end
         OP_PTR_READ: begin
            mem_re = 1'b1;
         end
         default: ;
      endcase
   end

   // allocation table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fat_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= fat_mem_ff[mem_raddr];
      end
   end

   // status back to the controller
   always_comb begin
      cc_ext           = LIMIT_W'(cluster_count_ff);
      limit            = ((cc_ext > USABLE_MAX) ? USABLE_MAX : cc_ext) + LIMIT_W'(2);
      sts.kind         = kind_ff;
      sts.clr_last     = &clr_ff;
      sts.cl_in_table  = ({1'b0, cl_ff} < TABLE_LIMIT);
      sts.ptr_is_stop  = (ptr_ff == ENTRY_FREE) || (ptr_ff >= ENTRY_END_MIN);
      sts.ptr_in_table = ({1'b0, ptr_ff} < TABLE_LIMIT);
      sts.scan_end     = ({1'b0, ptr_ff} >= limit);
      sts.entry_free   = (rdata_ff == ENTRY_FREE);
      sts.first_zero   = (first_ff == '0);
      sts.need_zero    = (need_ff == '0);
      sts.alloc_last   = ((NEED_W'(count_ff) + NEED_W'(1)) == need_ff);
   end

   // result assembly: data lba of the selected cluster
   always_comb begin
      case (cmd.res.val_sel)
         VAL_RDATA: res_val = rdata_ff;
         VAL_FIRST: res_val = CLUSTER_W'(first_ff);
         default:   res_val = '0;
      endcase
      case (cmd.res.addr_sel)
         ADDR_REQ:   lba_cl = cl_ff;
         ADDR_FIRST: lba_cl = CLUSTER_W'(first_ff);
         default:    lba_cl = '0;
      endcase
      lba = data_start_ff + ((LBA_W'(lba_cl) - LBA_W'(2)) << cluster_shift_ff);
      rsp_in.status         = cmd.res.status;
      rsp_in.value          = res_val;
      rsp_in.sector_address = (cmd.res.addr_sel == ADDR_ZERO) ? '0 : lba;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[design/fccm_ctrl.sv]
// fccm_ctrl: request sequencer for read, write, allocate and free, plus the
// table clearing pass after reset and the result handshake. Depends on fccm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccm_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  fccm_pkg::dp_sts_type  sts,
   output fccm_pkg::dp_cmd_type  cmd
);
   import fccm_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_READ_DATA,
      S_FREE_CHECK,
      S_FREE_CLEAR,
      S_SCAN_CHECK,
      S_SCAN_TEST,
      S_MARK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      cleanup_ff, cleanup_in;
   fin_type   fin_ff, fin_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cleanup_in   = cleanup_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_IDLE;
      cmd.fin      = 1'b0;
      cmd.res      = fin_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.kind)
               KIND_READ: begin
                  if (!sts.cl_in_table) begin
                     fin_in   = '{ST_RANGE, VAL_ZERO, ADDR_REQ};
                     state_in = S_FINISH;
                  end else begin
                     cmd.op   = OP_READ_ENTRY;
                     state_in = S_READ_DATA;
                  end
               end
               KIND_WRITE: begin
                  if (!sts.cl_in_table) begin
                     fin_in = '{ST_RANGE, VAL_ZERO, ADDR_REQ};
                  end else begin
                     cmd.op = OP_WRITE_ENTRY;
                     fin_in = '{ST_OK, VAL_ZERO, ADDR_REQ};
                  end
                  state_in = S_FINISH;
               end
               KIND_ALLOC: begin
                  if (sts.need_zero) begin
                     fin_in   = '{ST_OK, VAL_ZERO, ADDR_ZERO};
                     state_in = S_FINISH;
                  end else begin
                     cmd.op   = OP_SCAN_START;
                     state_in = S_SCAN_CHECK;
                  end
               end
               KIND_FREE: begin
                  cleanup_in = 1'b0;
                  state_in   = S_FREE_CHECK;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_READ_DATA: begin
            fin_in   = '{ST_OK, VAL_RDATA, ADDR_REQ};
            state_in = S_FINISH;
         end
         // chain walk: stop at free or end mark, flag links leaving the table
         S_FREE_CHECK: begin
            if (sts.ptr_is_stop || !sts.ptr_in_table) begin
               if (cleanup_ff) begin
                  fin_in = '{ST_NOSPACE, VAL_ZERO, ADDR_ZERO};
               end else if (sts.ptr_is_stop) begin
                  fin_in = '{ST_OK, VAL_ZERO, ADDR_REQ};
               end else begin
                  fin_in = '{ST_RANGE, VAL_ZERO, ADDR_REQ};
               end
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_PTR_READ;
               state_in = S_FREE_CLEAR;
            end
         end
         S_FREE_CLEAR: begin
            cmd.op   = OP_FREE_CLEAR;
            state_in = S_FREE_CHECK;
         end
         // free cluster search; out of space unwinds the partial chain
         S_SCAN_CHECK: begin
            if (sts.scan_end) begin
               if (sts.first_zero) begin
                  fin_in   = '{ST_NOSPACE, VAL_ZERO, ADDR_ZERO};
                  state_in = S_FINISH;
               end else begin
                  cmd.op     = OP_UNWIND;
                  cleanup_in = 1'b1;
                  state_in   = S_FREE_CHECK;
               end
            end else begin
               cmd.op   = OP_PTR_READ;
               state_in = S_SCAN_TEST;
            end
         end
         S_SCAN_TEST: begin
            if (sts.entry_free) begin
               cmd.op   = OP_LINK;
               state_in = S_MARK;
            end else begin
               cmd.op   = OP_SCAN_NEXT;
               state_in = S_SCAN_CHECK;
            end
         end
         S_MARK: begin
            cmd.op = OP_MARK;
            if (sts.alloc_last) begin
               fin_in   = '{ST_OK, VAL_FIRST, ADDR_FIRST};
               state_in = S_FINISH;
            end else begin
               state_in = S_SCAN_CHECK;
            end
         end
         // load the result register once the previous beat is gone
         S_FINISH: begin
            if (slot_free) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cleanup_ff   <= 1'b0;
         fin_ff       <= '{ST_OK, VAL_ZERO, ADDR_ZERO};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cleanup_ff   <= cleanup_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[design/fat_cluster_chain_manager_unit.sv]
// A free clears each chain entry in turn; an allocate skips occupied clusters and
// links free ones, and on running out of space unwinds any partial chain.
// One request at a time; the table memory has one write and one read port.
// Reset is synchronous; afterwards a clearing pass zeroes the table
// with req_ready low. A result beat may wait while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module fat_cluster_chain_manager_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  fccm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output fccm_pkg::rsp_type                rsp_data,
   input  wire                              csr_we,
   input  wire  [fccm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [fccm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fccm_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer
   fccm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, registers and result
   fccm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[design/fccm_checker.sv]
// fccm_checker: port-level assertions for fat_cluster_chain_manager_unit, bound
// to the top level. Depends on fccm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccm_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input fccm_pkg::rsp_type rsp_data
);
   import fccm_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one request in flight: ready drops right after a beat is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // table clearing pass keeps the input closed after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block open right after reset");

   // out of space reports no cluster and no address
   a_nospace_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NOSPACE |->
         rsp_data.value == '0 && rsp_data.sector_address == '0)
      else $error("out of space result carries data");

   // out of range never returns an entry
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_RANGE |-> rsp_data.value == '0)
      else $error("out of range result carries a value");

endmodule

bind fat_cluster_chain_manager_unit fccm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
